FILE: rtl/cspmv_pkg.sv
// ----------------------------------------------------------------------------
// cspmv_pkg
// Shared constants, codes and types of the CSR sparse matrix-vector unit.
// ----------------------------------------------------------------------------
package cspmv_pkg;

  localparam int unsigned MAX_N      = 1024;
  localparam int unsigned VEC_AW     = $clog2(MAX_N);
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned SIZE_LIM   = (MAX_N < 1024) ? MAX_N : 1024;
  localparam int unsigned SIZE_RST   = 1024;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned APB_AW     = 2;
  localparam int unsigned APB_DW     = 32;

  localparam logic [APB_AW-1:0] ADDR_MATRIX_SIZE = APB_AW'(0);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_NZ    = 2'd1,
    REQ_EMPTY = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic signed [VAL_W-1:0] row_result;
    logic signed [VAL_W-1:0] diag_value;
    logic                    last_row;
    logic                    index_error;
  } cspmv_res_t;

  typedef struct packed {
    logic s1_v;
    logic s2_v;
    logic rec_v;
  } cspmv_pipe_stat_t;

endpackage

FILE: rtl/cspmv_if.sv
// ----------------------------------------------------------------------------
// cspmv_if
// Request and result channels: valid/ready handshake with payload fields.
// ----------------------------------------------------------------------------
interface cspmv_req_if;
  import cspmv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    last_in_row;

  modport source (output valid, req_type, index, value, last_in_row, input ready);
  modport sink   (input valid, req_type, index, value, last_in_row, output ready);
endinterface

interface cspmv_res_if;
  import cspmv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row_index;
  logic signed [VAL_W-1:0] row_result;
  logic signed [VAL_W-1:0] diag_value;
  logic                    last_row;
  logic                    index_error;

  modport source (output valid, row_index, row_result, diag_value, last_row, index_error,
                  input ready);
  modport sink   (input valid, row_index, row_result, diag_value, last_row, index_error,
                  output ready);
endinterface

FILE: rtl/cspmv_vec_mem.sv
// ----------------------------------------------------------------------------
// cspmv_vec_mem
// Dense vector store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cspmv_vec_mem (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [cspmv_pkg::VEC_AW-1:0]      waddr_i,
  input  logic signed [cspmv_pkg::VAL_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [cspmv_pkg::VEC_AW-1:0]      raddr_i,
  output logic signed [cspmv_pkg::VAL_W-1:0] rdata_o
);
  import cspmv_pkg::*;

  logic signed [VAL_W-1:0] mem [MAX_N];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cspmv_mac.sv
// ----------------------------------------------------------------------------
// cspmv_mac
// Multiply, saturating accumulate, diagonal capture and row result format.
// ----------------------------------------------------------------------------
module cspmv_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                nz_i,
  input  logic [cspmv_pkg::IDX_W-1:0]         index_i,
  input  logic signed [cspmv_pkg::VAL_W-1:0]  value_i,
  input  logic                                last_i,
  input  logic signed [cspmv_pkg::VAL_W-1:0]  vec_rdata_i,
  input  logic [cspmv_pkg::SIZE_W-1:0]        eff_size_i,
  output cspmv_pkg::cspmv_pipe_stat_t         stat_o,
  output logic                                push_o,
  output cspmv_pkg::cspmv_res_t               push_data_o
);
  import cspmv_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] RES_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] RES_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // stage 1: vector read in flight
  logic                    s1_v_q;
  logic                    s1_nz_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic signed [VAL_W-1:0] s1_val_q;
  logic                    s1_last_q;

  // stage 2: product
  logic                    s2_v_q;
  logic                    s2_nz_q;
  logic [IDX_W-1:0]        s2_idx_q;
  logic signed [VAL_W-1:0] s2_val_q;
  logic                    s2_last_q;
  logic signed [ACC_W-1:0] s2_prod_q;

  // row state
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [VAL_W-1:0] hold_q, hold_d;
  logic                    seen_q, seen_d;
  logic [IDX_W-1:0]        row_q, row_d;
  logic                    err_q, err_d;

  // finished row record
  logic                    rec_v_q;
  logic signed [ACC_W-1:0] rec_acc_q;
  logic signed [VAL_W-1:0] rec_diag_q;
  logic                    rec_last_q;
  logic                    rec_err_q;
  logic [IDX_W-1:0]        rec_row_q;

  logic                    in_rng;
  logic                    use_nz;
  logic signed [ACC_W-1:0] sum;
  logic                    ovf;
  logic signed [ACC_W-1:0] acc_new;
  logic                    take_diag;
  logic signed [VAL_W-1:0] diag_new;
  logic                    seen_new;
  logic                    err_new;
  logic                    row_end;
  logic                    last_row;
  logic [ACC_W-17:0]       shifted;
  logic signed [VAL_W-1:0] res_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      rec_v_q <= 1'b0;
      acc_q   <= '0;
      hold_q  <= '0;
      seen_q  <= 1'b0;
      row_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      s1_v_q  <= start_i;
      s2_v_q  <= s1_v_q;
      rec_v_q <= row_end;
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      seen_q  <= seen_d;
      row_q   <= row_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_nz_q    <= nz_i;
    s1_idx_q   <= index_i;
    s1_val_q   <= value_i;
    s1_last_q  <= last_i;
    s2_nz_q    <= s1_nz_q;
    s2_idx_q   <= s1_idx_q;
    s2_val_q   <= s1_val_q;
    s2_last_q  <= s1_last_q;
    s2_prod_q  <= s1_val_q * vec_rdata_i;
    rec_acc_q  <= acc_new;
    rec_diag_q <= seen_new ? diag_new : '0;
    rec_last_q <= last_row;
    rec_err_q  <= err_new;
    rec_row_q  <= row_q;
  end

  always_comb begin
    in_rng    = {1'b0, s2_idx_q} < eff_size_i;
    use_nz    = s2_v_q && s2_nz_q && in_rng;
    sum       = acc_q + s2_prod_q;
    ovf       = (acc_q[ACC_W-1] == s2_prod_q[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1]);
    acc_new   = acc_q;
    if (use_nz) begin
      acc_new = ovf ? (acc_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
    end
    take_diag = use_nz && (s2_idx_q == row_q) && !seen_q;
    diag_new  = take_diag ? s2_val_q : hold_q;
    seen_new  = seen_q | take_diag;
    err_new   = err_q | (s2_v_q && s2_nz_q && !in_rng);
    row_end   = s2_v_q && (!s2_nz_q || s2_last_q);
    last_row  = {1'b0, row_q} >= (eff_size_i - SIZE_W'(1));

    if (row_end) begin
      acc_d  = '0;
      hold_d = '0;
      seen_d = 1'b0;
      err_d  = 1'b0;
      row_d  = last_row ? '0 : row_q + IDX_W'(1);
    end else begin
      acc_d  = acc_new;
      hold_d = diag_new;
      seen_d = seen_new;
      err_d  = err_new;
      row_d  = row_q;
    end
  end

  // floor shift by 16, saturate to 32 bits
  always_comb begin
    shifted = rec_acc_q[ACC_W-1:16];
    if (&shifted[ACC_W-17:VAL_W-1] || ~|shifted[ACC_W-17:VAL_W-1]) begin
      res_val = shifted[VAL_W-1:0];
    end else begin
      res_val = shifted[ACC_W-17] ? RES_MIN : RES_MAX;
    end
  end

  assign push_o                  = rec_v_q;
  assign push_data_o.row_index   = rec_row_q;
  assign push_data_o.row_result  = res_val;
  assign push_data_o.diag_value  = rec_diag_q;
  assign push_data_o.last_row    = rec_last_q;
  assign push_data_o.index_error = rec_err_q;

  assign stat_o.s1_v  = s1_v_q;
  assign stat_o.s2_v  = s2_v_q;
  assign stat_o.rec_v = rec_v_q;

endmodule

FILE: rtl/cspmv_out_fifo.sv
// ----------------------------------------------------------------------------
// cspmv_out_fifo
// Result queue between the accumulate pipeline and the result channel.
// ----------------------------------------------------------------------------
module cspmv_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  cspmv_pkg::cspmv_res_t        push_data_i,
  output logic [cspmv_pkg::FIFO_AW:0]  cnt_o,
  cspmv_res_if.source                  res_o
);
  import cspmv_pkg::*;

  cspmv_res_t           buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 pop;
  cspmv_res_t           head;

  assign pop = res_o.valid && res_o.ready;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head              = buf_q[rd_ptr_q];
  assign res_o.valid       = cnt_q != '0;
  assign res_o.row_index   = head.row_index;
  assign res_o.row_result  = head.row_result;
  assign res_o.diag_value  = head.diag_value;
  assign res_o.last_row    = head.last_row;
  assign res_o.index_error = head.index_error;
  assign cnt_o             = cnt_q;

endmodule

FILE: rtl/csr_spmv_with_diagonal_unit.sv
// ----------------------------------------------------------------------------
// csr_spmv_with_diagonal_unit
// Streaming CSR sparse matrix-vector multiply with diagonal extraction.
// Row path: stage 1, stage 2, row record, then the result queue.
// Throughput: one item per cycle; the 8-entry result queue gates input
// acceptance by counting results in flight when the result sink stalls.
// Reset: row state, pipeline and result queue clear, matrix_size returns to 1024; the
// vector store holds undefined data until loaded.
// ----------------------------------------------------------------------------
module csr_spmv_with_diagonal_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cspmv_req_if.sink                         req_i,
  cspmv_res_if.source                       res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cspmv_pkg::APB_AW-1:0]      paddr,
  input  logic [cspmv_pkg::APB_DW-1:0]      pwdata,
  output logic [cspmv_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);
  import cspmv_pkg::*;

  localparam int unsigned CRED_W = FIFO_AW + 2;

  logic [SIZE_W-1:0]        size_q;
  logic [SIZE_W-1:0]        eff_size;
  logic                     accept;
  logic                     is_load;
  logic                     is_nz;
  logic                     is_empty;
  logic [IDX_W+VEC_AW-1:0]  idx_ext;
  logic                     load_ok;
  logic signed [VAL_W-1:0]  vec_rdata;
  cspmv_pipe_stat_t         stat;
  logic                     push;
  cspmv_res_t               push_data;
  logic [FIFO_AW:0]         fifo_cnt;
  logic [CRED_W-1:0]        in_flight;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(SIZE_RST);
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MATRIX_SIZE)) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MATRIX_SIZE) ? APB_DW'(size_q) : '0;

  always_comb begin
    if (size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_q > SIZE_W'(SIZE_LIM)) begin
      eff_size = SIZE_W'(SIZE_LIM);
    end else begin
      eff_size = size_q;
    end
  end

  // request decode and admission
  always_comb begin
    is_load  = 1'b0;
    is_nz    = 1'b0;
    is_empty = 1'b0;
    case (req_i.req_type)
      REQ_LOAD:  is_load  = 1'b1;
      REQ_NZ:    is_nz    = 1'b1;
      REQ_EMPTY: is_empty = 1'b1;
      default:   ;
    endcase
  end

  assign in_flight = CRED_W'(fifo_cnt) + CRED_W'(stat.s1_v) + CRED_W'(stat.s2_v)
                   + CRED_W'(stat.rec_v);
  assign req_i.ready = in_flight < CRED_W'(FIFO_DEPTH);
  assign accept      = req_i.valid && req_i.ready;
  assign idx_ext     = {{VEC_AW{1'b0}}, req_i.index};
  assign load_ok     = idx_ext < (IDX_W+VEC_AW)'(MAX_N);

  cspmv_vec_mem u_vec_mem (
    .clk_i   (clk_i),
    .we_i    (accept && is_load && load_ok),
    .waddr_i (idx_ext[VEC_AW-1:0]),
    .wdata_i (req_i.value),
    .re_i    (accept && is_nz),
    .raddr_i (idx_ext[VEC_AW-1:0]),
    .rdata_o (vec_rdata)
  );

  cspmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (is_nz || is_empty)),
    .nz_i        (is_nz),
    .index_i     (req_i.index),
    .value_i     (req_i.value),
    .last_i      (req_i.last_in_row),
    .vec_rdata_i (vec_rdata),
    .eff_size_i  (eff_size),
    .stat_o      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cspmv_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .cnt_o       (fifo_cnt),
    .res_o       (res_o)
  );

endmodule
